// ===== hdl/hcd_pkg.sv =====
// Shared types and constants for the chunked body dechunker.
// Holds request, result, configuration and parser state types and the phase codes.
// No dependencies.
package hcd_pkg;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_SEMI  = 8'h3B;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_NUM   = 3'd1;
  localparam logic [2:0] PH_OPT   = 3'd2;
  localparam logic [2:0] PH_HCRLF = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_DCR   = 3'd5;
  localparam logic [2:0] PH_DLF   = 3'd6;
  localparam logic [2:0] PH_RAW   = 3'd7;

  localparam logic [0:0] REG_BROKEN_MODE = 1'd0;
  localparam logic [0:0] REG_GOOD_LIMIT  = 1'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       segment_last;
  } hcd_req_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       raw_passthrough;
    logic       chunk_last;
    logic       body_end;
    logic       end_misplaced;
  } hcd_res_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [15:0] data;
  } hcd_cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] remaining;
    logic [15:0] good_left;
  } hcd_state_t;

  typedef struct packed {
    logic        broken_mode;
    logic [15:0] good_limit;
  } hcd_ctrl_t;

endpackage

// ===== hdl/hcd_stream_if.sv =====
// Valid/ready channel carrying one payload of type T per request.
// Depends on nothing; payload types come from hcd_pkg at the instantiation.
interface hcd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/hcd_parse.sv =====
// One-byte parser step: next parser state and result from current state and a request.
// Depends on hcd_pkg.
module hcd_parse import hcd_pkg::*; (
  input  hcd_state_t state_i,
  input  hcd_req_t   req_i,
  input  hcd_ctrl_t  ctrl_i,
  output hcd_state_t state_o,
  output hcd_res_t   res_o
);

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  logic [7:0]  c;
  logic        is_blank;
  logic        is_crlf;
  logic [3:0]  hex;
  logic [2:0]  ph;
  logic [31:0] rem;
  logic [15:0] gcl;
  logic        dlf_take;
  logic        dlf_raw;
  hcd_res_t    res;

  assign c        = req_i.data_byte;
  assign is_blank = (c == CHR_SPACE) || (c == CHR_TAB);
  assign is_crlf  = (c == CHR_CR) || (c == CHR_LF);
  assign hex      = hex_value(c);

  always_comb begin
    ph  = state_i.phase;
    rem = state_i.remaining;
    gcl = state_i.good_left;
    res = '0;
    if (req_i.restart) begin
      ph  = PH_LEAD;
      rem = '0;
      gcl = ctrl_i.good_limit;
    end
    if (ctrl_i.broken_mode && gcl == '0) begin
      ph = PH_RAW;
    end
    dlf_take = ctrl_i.broken_mode && (gcl != '0);
    dlf_raw  = dlf_take && (gcl == 16'd1);

    unique case (ph)
      PH_LEAD: begin
        if (!is_blank && !is_crlf) begin
          if (c == CHR_SEMI) begin
            ph = PH_OPT;
          end else begin
            ph  = PH_NUM;
            rem = {rem[27:0], hex};
          end
        end
      end
      PH_NUM, PH_OPT: begin
        if (c == CHR_CR) begin
          ph = PH_HCRLF;
        end else if (c == CHR_LF) begin
          if (rem != '0) begin
            ph = PH_DATA;
          end else begin
            ph                = PH_LEAD;
            res.body_end      = 1'b1;
            res.end_misplaced = !req_i.segment_last;
          end
        end else if (c == CHR_SEMI || is_blank) begin
          ph = PH_OPT;
        end else if (ph == PH_NUM) begin
          rem = {rem[27:0], hex};
        end
      end
      PH_HCRLF: begin
        if (rem != '0) begin
          ph = PH_DATA;
        end else begin
          ph                = PH_LEAD;
          res.body_end      = 1'b1;
          res.end_misplaced = !req_i.segment_last;
        end
      end
      PH_DATA: begin
        res.payload_byte  = c;
        res.payload_valid = 1'b1;
        if (rem == 32'd1) begin
          ph             = PH_DCR;
          res.chunk_last = 1'b1;
        end
        rem = rem - 32'd1;
      end
      PH_DCR, PH_DLF: begin
        if (ph == PH_DCR && c != CHR_LF) begin
          ph = PH_DLF;
        end else begin
          if (dlf_take) gcl = gcl - 16'd1;
          if (dlf_raw) begin
            ph = PH_RAW;
          end else begin
            ph  = PH_LEAD;
            rem = '0;
          end
          if (!is_crlf) begin
            if (dlf_raw) begin
              res.payload_byte    = c;
              res.payload_valid   = 1'b1;
              res.raw_passthrough = 1'b1;
            end else if (!is_blank) begin
              if (c == CHR_SEMI) begin
                ph = PH_OPT;
              end else begin
                ph  = PH_NUM;
                rem = {28'd0, hex};
              end
            end
          end
        end
      end
      default: begin
        res.payload_byte    = c;
        res.payload_valid   = 1'b1;
        res.raw_passthrough = 1'b1;
      end
    endcase
  end

  assign state_o.phase     = ph;
  assign state_o.remaining = rem;
  assign state_o.good_left = gcl;
  assign res_o             = res;

endmodule

// ===== hdl/http_chunked_body_dechunker_core.sv =====
// Top level of the chunked body dechunker: input register, parser step, result register.
// Depends on hcd_pkg, hcd_stream_if and hcd_parse.
//
//   channel  modport  payload    role
//   req_i    sink     hcd_req_t  one body byte per request
//   cfg_i    sink     hcd_cfg_t  register writes, always ready
//   res_o    source   hcd_res_t  one result per request
//
// One byte per cycle sustained while res_o is ready; a request passes the input register, then the result register.
// The rate is set by the parser state loop, updated once per byte.
// rst_ni clears the parser, the control register and both stage valids at once; the data registers are not reset.
// While the result waits, the input register still takes one more request.
module http_chunked_body_dechunker_core import hcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  hcd_stream_if.sink   req_i,
  hcd_stream_if.sink   cfg_i,
  hcd_stream_if.source res_o
);

  hcd_ctrl_t  ctrl_q;
  hcd_state_t state_q;
  hcd_state_t state_d;
  logic       in_valid_q;
  hcd_req_t   in_data_q;
  logic       out_valid_q;
  hcd_res_t   out_data_q;
  hcd_res_t   res_d;
  logic       advance;

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_data_q;

  hcd_parse u_parse (
    .state_i (state_q),
    .req_i   (in_data_q),
    .ctrl_i  (ctrl_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        REG_BROKEN_MODE: ctrl_q.broken_mode <= cfg_i.payload.data[0];
        REG_GOOD_LIMIT:  ctrl_q.good_limit  <= cfg_i.payload.data;
        default:         ctrl_q             <= ctrl_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PH_LEAD;
      state_q.remaining <= '0;
      state_q.good_left <= '0;
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_data_q <= req_i.payload;
    end
    if (advance) begin
      out_data_q <= res_d;
    end
  end

endmodule

// ===== hdl/hcd_checker.sv =====
// Port-level checks for the chunked body dechunker, bound to its top level.
// Depends on hcd_pkg and the top level's ports.
module hcd_checker import hcd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     res_valid,
  input logic     res_ready,
  input hcd_res_t res_data
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result dropped or changed while stalled");

  a_raw_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_data.raw_passthrough |-> res_data.payload_valid && !res_data.chunk_last)
    else $error("raw byte flagged without payload or with chunk end");

  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_data.chunk_last |-> res_data.payload_valid && !res_data.body_end)
    else $error("chunk end flagged on a framing byte");

  a_end_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_data.body_end || res_data.end_misplaced)
      |-> res_data.body_end && !res_data.payload_valid)
    else $error("body end on a payload byte or misplaced flag alone");

endmodule

bind http_chunked_body_dechunker_core hcd_checker u_hcd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_data  (res_o.payload)
);

// ===== sim/http_chunked_body_dechunker_core_test.sv =====
// Self-checking testbench for http_chunked_body_dechunker_core: drives directed and random
// chunked bodies with random stalls on both channels and checks each result in order.
// Depends on hcd_pkg, hcd_stream_if and the core.
module http_chunked_body_dechunker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hcd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int IDLE_LIMIT      = 2000;
  localparam int PHASE_ITEMS     = 125;

  class dechunk_scoreboard;
    logic        broken_mode;
    logic [15:0] good_limit;
    logic [2:0]  parse_phase;
    logic [31:0] size_left;
    logic [15:0] good_left;
    hcd_res_t    byte_results_q[$];
    int          errors;
    int          n_checked;

    function new();
      broken_mode = 1'b0;
      good_limit  = '0;
      parse_phase = PH_LEAD;
      size_left   = '0;
      good_left   = '0;
      errors      = 0;
      n_checked   = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CHR_SPACE || c == CHR_TAB;
    endfunction

    function bit is_crlf(logic [7:0] c);
      return c == CHR_CR || c == CHR_LF;
    endfunction

    function void write_reg(hcd_cfg_t w);
      if (w.index == REG_BROKEN_MODE) broken_mode = w.data[0];
      else if (w.index == REG_GOOD_LIMIT) good_limit = w.data;
    endfunction

    function void dechunk_byte(hcd_req_t r);
      hcd_res_t   res;
      logic [7:0] c;
      logic [3:0] nib;
      bit         again;
      bit         to_raw;
      c = r.data_byte;
      res = '0;
      if (r.restart) begin
        parse_phase = PH_LEAD;
        size_left   = '0;
        good_left   = good_limit;
      end
      if (broken_mode && good_left == 0) parse_phase = PH_RAW;
      again = 1'b1;
      for (int g = 0; g < 8 && again; g++) begin
        again = 1'b0;
        case (parse_phase)
          PH_LEAD: begin
            if (!is_blank(c) && !is_crlf(c)) begin
              parse_phase = PH_NUM;
              again = 1'b1;
            end
          end
          PH_NUM: begin
            if (c == CHR_CR) parse_phase = PH_HCRLF;
            else if (c == CHR_LF) begin
              parse_phase = PH_HCRLF;
              again = 1'b1;
            end else if (c == CHR_SEMI || is_blank(c)) parse_phase = PH_OPT;
            else begin
              if (c >= "0" && c <= "9") nib = c[3:0];
              else if (c >= "a" && c <= "f") nib = c[3:0] + 4'd9;
              else if (c >= "A" && c <= "F") nib = c[3:0] + 4'd9;
              else nib = '0;
              size_left = {size_left[27:0], nib};
            end
          end
          PH_OPT: begin
            if (c == CHR_CR) parse_phase = PH_HCRLF;
            else if (c == CHR_LF) begin
              parse_phase = PH_HCRLF;
              again = 1'b1;
            end
          end
          PH_HCRLF: begin
            if (size_left != 0) parse_phase = PH_DATA;
            else begin
              parse_phase       = PH_LEAD;
              res.body_end      = 1'b1;
              res.end_misplaced = !r.segment_last;
            end
          end
          PH_DATA: begin
            res.payload_byte  = c;
            res.payload_valid = 1'b1;
            size_left         = size_left - 32'd1;
            if (size_left == 0) begin
              parse_phase    = PH_DCR;
              res.chunk_last = 1'b1;
            end
          end
          PH_DCR: begin
            parse_phase = PH_DLF;
            if (c == CHR_LF) again = 1'b1;
          end
          PH_DLF: begin
            to_raw = 1'b0;
            if (broken_mode && good_left != 0) begin
              good_left = good_left - 16'd1;
              to_raw    = (good_left == 0);
            end
            if (to_raw) parse_phase = PH_RAW;
            else begin
              parse_phase = PH_LEAD;
              size_left   = '0;
            end
            if (!is_crlf(c)) again = 1'b1;
          end
          default: begin
            res.payload_byte    = c;
            res.payload_valid   = 1'b1;
            res.raw_passthrough = 1'b1;
          end
        endcase
      end
      byte_results_q.push_back(res);
    endfunction

    task report(string msg);
      if (errors < 30) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_output(hcd_res_t got);
      hcd_res_t exp;
      string    diff;
      n_checked++;
      if (byte_results_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request pending", n_checked));
      end else begin
        exp  = byte_results_q.pop_front();
        diff = "";
        if (got.payload_byte !== exp.payload_byte) diff = {diff, " payload_byte"};
        if (got.payload_valid !== exp.payload_valid) diff = {diff, " payload_valid"};
        if (got.raw_passthrough !== exp.raw_passthrough) diff = {diff, " raw_passthrough"};
        if (got.chunk_last !== exp.chunk_last) diff = {diff, " chunk_last"};
        if (got.body_end !== exp.body_end) diff = {diff, " body_end"};
        if (got.end_misplaced !== exp.end_misplaced) diff = {diff, " end_misplaced"};
        if (diff != "")
          report($sformatf("result %0d mismatch in%s: got %h expected %h",
                           n_checked, diff, got, exp));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  hcd_stream_if #(.T(hcd_req_t)) req_if ();
  hcd_stream_if #(.T(hcd_cfg_t)) cfg_if ();
  hcd_stream_if #(.T(hcd_res_t)) res_if ();

  http_chunked_body_dechunker_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  dechunk_scoreboard sb = new();

  int   max_gap = 10;
  bit   hold_off_req = 1'b0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  logic restart_next = 1'b0;
  bit   need_restart = 1'b0;

  logic        mode_plan  [8] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  logic [15:0] limit_plan [8] = '{16'd0, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'd2, 16'd0, 16'd0};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.payload <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.payload <= '0;
    res_if.ready <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) sb.check_output(res_if.payload);
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.payload);
      if (req_if.valid && req_if.ready) sb.dechunk_byte(req_if.payload);
      if ((res_if.valid && res_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (req_if.valid && req_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = $urandom_range(0, max_gap);
      if (hold_off_req) begin
        gap = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  function automatic bit coin(int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic logic [7:0] rand_byte(int lo, int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  task automatic send_byte(logic [7:0] b, logic rs, logic sl);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= '{data_byte: b, restart: rs, segment_last: sl};
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic emit(logic [7:0] b, logic sl);
    send_byte(b, restart_next, sl);
    restart_next = 1'b0;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.byte_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(logic mode, logic [15:0] limit);
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= '{index: REG_BROKEN_MODE, data: {15'd0, mode}};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.payload <= '{index: REG_GOOD_LIMIT, data: limit};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic emit_blank();
    case ($urandom_range(0, 3))
      0: emit(CHR_SPACE, coin(8));
      1: emit(CHR_TAB, coin(8));
      2: emit(CHR_CR, coin(8));
      default: emit(CHR_LF, coin(8));
    endcase
  endtask

  task automatic emit_size(logic [31:0] size);
    logic [3:0] nib;
    int         n;
    n = 1;
    while (n < 8 && (size >> (4 * n)) != 0) n++;
    if (coin(4)) emit("0", coin(8));
    for (int i = n - 1; i >= 0; i--) begin
      nib = size[4 * i +: 4];
      if (nib < 10) emit(8'h30 + {4'd0, nib}, coin(8));
      else emit((coin(2) ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10, coin(8));
    end
  endtask

  task automatic send_message();
    int          chunks;
    logic [31:0] size;
    restart_next = need_restart || !coin(4);
    need_restart = 1'b0;
    max_gap = coin(4) ? 0 : 10;
    chunks = $urandom_range(0, 4);
    for (int k = 0; k < chunks; k++) begin
      if (coin(4)) repeat ($urandom_range(1, 2)) emit_blank();
      if (coin(30)) begin
        // wrap the size counter, then bail out until the next restart
        repeat (9) emit("F", coin(8));
        emit(CHR_CR, coin(8));
        emit(CHR_LF, coin(8));
        repeat ($urandom_range(1, 6)) emit(rand_byte(0, 255), coin(8));
        need_restart = 1'b1;
        return;
      end
      size = coin(10) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (coin(20)) emit($urandom_range(0, 1) ? "g" : "z", coin(8));
      emit_size(size);
      case ($urandom_range(0, 3))
        0: begin
          emit(CHR_SEMI, coin(8));
          repeat ($urandom_range(0, 3)) emit(rand_byte(8'h21, 8'h7e), coin(8));
        end
        1: emit(coin(2) ? CHR_SPACE : CHR_TAB, coin(8));
        default: ;
      endcase
      if (coin(5)) emit(CHR_LF, coin(8));
      else begin
        emit(CHR_CR, coin(8));
        emit(coin(10) ? rand_byte(0, 255) : CHR_LF, coin(8));
      end
      repeat (size) emit(rand_byte(0, 255), coin(8));
      case ($urandom_range(0, 5))
        0: ;
        1: emit(CHR_LF, coin(8));
        2: emit(CHR_CR, coin(8));
        default: begin
          emit(CHR_CR, coin(8));
          emit(CHR_LF, coin(8));
        end
      endcase
    end
    if (!coin(5)) begin
      emit("0", coin(8));
      if (coin(4)) begin
        emit(CHR_SEMI, coin(8));
        emit("x", coin(8));
      end
      emit(CHR_CR, coin(8));
      emit(CHR_LF, !coin(6));
    end
  endtask

  initial begin
    logic [7:0] dir_bytes [23] = '{CHR_SPACE, CHR_TAB, CHR_CR, CHR_LF, "g", "2", CHR_SEMI,
                                   "x", CHR_CR, "Q", 8'hFF, 8'h00, CHR_CR, "1", CHR_LF,
                                   8'h5A, CHR_LF, "0", CHR_SPACE, CHR_CR, CHR_LF, "0",
                                   CHR_LF};
    int target;
    limit_plan[6] = 16'($urandom_range(3, 6));
    limit_plan[7] = 16'($urandom_range(0, 65535));
    wait (rst_ni);
    @(posedge clk_i);

    for (int i = 0; i < 23; i++) send_byte(dir_bytes[i], i == 0, i == 22);

    for (int p = 0; p < 8; p++) begin
      drain();
      write_regs(mode_plan[p], limit_plan[p]);
      if (p == 2) hold_off_req = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (coin(7)) begin
          max_gap = coin(2) ? 0 : 10;
          repeat ($urandom_range(1, 8))
            send_byte(rand_byte(0, 255), coin(16), coin(8));
        end else begin
          send_message();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.byte_results_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.byte_results_q.size()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
